### rtl/soil_moisture_conditioner_macros.svh
// ----------------------------------------------------------------------------
// Soil moisture conditioner assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SOIL_MOISTURE_CONDITIONER_MACROS_SVH
`define SOIL_MOISTURE_CONDITIONER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SMC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("soil moisture conditioner check failed");

// next-cycle implication, disabled during reset
`define SMC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("soil moisture conditioner check failed");

`endif

### rtl/smc_pkg.sv
// ----------------------------------------------------------------------------
// Soil moisture conditioner package
// Types, register codes, widths and the duration table.
// ----------------------------------------------------------------------------
package smc_pkg;

   localparam int MV_W      = 16;
   localparam int PCT_W     = 7;
   localparam int SEC_W     = 8;
   localparam int CSR_IDX_W = 3;
   localparam int QUO_W     = 7;
   // (dry - reading) * 100 + span / 2 stays below 2^23
   localparam int REM_W     = 23;
   localparam int DIV_STEPS = QUO_W;

   localparam logic [MV_W-1:0]  MV_MAX         = 16'hFFFF;
   localparam logic [PCT_W-1:0] PCT_FULL_SCALE = 7'd100;
   localparam logic [PCT_W-1:0] PCT_NONE       = 7'd0;
   localparam logic [PCT_W-1:0] PCT_NO_WATER   = 7'd81;
   localparam logic [PCT_W-1:0] PCT_SHORT      = 7'd80;
   localparam logic [PCT_W-1:0] PCT_BAND_70    = 7'd70;
   localparam logic [PCT_W-1:0] PCT_BAND_60    = 7'd60;
   localparam logic [PCT_W-1:0] PCT_BAND_50    = 7'd50;

   localparam logic [SEC_W-1:0] SEC_0   = 8'd0;
   localparam logic [SEC_W-1:0] SEC_10  = 8'd10;
   localparam logic [SEC_W-1:0] SEC_60  = 8'd60;
   localparam logic [SEC_W-1:0] SEC_120 = 8'd120;
   localparam logic [SEC_W-1:0] SEC_180 = 8'd180;
   localparam logic [SEC_W-1:0] SEC_240 = 8'd240;

   localparam logic [MV_W-1:0] DRY_RESET      = 16'd2800;
   localparam logic [MV_W-1:0] WET_RESET      = 16'd1200;
   localparam logic [MV_W-1:0] KNEE_RESET     = 16'd3300;
   localparam logic [MV_W-1:0] LOW_MARG_RESET = 16'd300;
   localparam logic [MV_W-1:0] HI_MARG_RESET  = 16'd300;
   localparam logic [MV_W-1:0] HEADROOM_RESET = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRY_LEVEL    = 3'd0,
      CSR_WET_LEVEL    = 3'd1,
      CSR_SUPPLY_KNEE  = 3'd2,
      CSR_LOW_MARGIN   = 3'd3,
      CSR_HIGH_MARGIN  = 3'd4,
      CSR_DRY_HEADROOM = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [MV_W-1:0] dry_level_mv;
      logic [MV_W-1:0] wet_level_mv;
      logic [MV_W-1:0] supply_knee_mv;
      logic [MV_W-1:0] low_margin_mv;
      logic [MV_W-1:0] high_margin_mv;
      logic [MV_W-1:0] dry_headroom_mv;
   } cfg_type;

   typedef enum logic [1:0] {
      PCT_SEL_ZERO   = 2'd0,
      PCT_SEL_FULL   = 2'd1,
      PCT_SEL_DIVIDE = 2'd2
   } pct_sel_type;

   // word as it moves through the divider and back end
   typedef struct packed {
      logic [MV_W-1:0]  adjusted_mv;
      logic             plausible;
      logic             manual_run;
      pct_sel_type      pct_sel;
      logic [MV_W-1:0]  span;
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } pipe_type;

   function automatic logic [SEC_W-1:0] table_seconds(input logic [PCT_W-1:0] pct);
      logic [SEC_W-1:0] secs;
      if (pct >= PCT_NO_WATER) begin
         secs = SEC_0;
      end else if (pct == PCT_SHORT) begin
         secs = SEC_10;
      end else if (pct >= PCT_BAND_70) begin
         secs = SEC_60;
      end else if (pct >= PCT_BAND_60) begin
         secs = SEC_120;
      end else if (pct >= PCT_BAND_50) begin
         secs = SEC_180;
      end else begin
         secs = SEC_240;
      end
      return secs;
   endfunction

endpackage

### rtl/smc_channels.sv
// ----------------------------------------------------------------------------
// Soil moisture conditioner channels
// Valid/ready interfaces for the sample and result words.
// ----------------------------------------------------------------------------
interface smc_req_if;
   logic                        valid;
   logic                        ready;
   logic [smc_pkg::MV_W-1:0]    sensor_reading_mv;
   logic [smc_pkg::MV_W-1:0]    supply_mv;
   logic                        manual_run;

   modport source (output valid, output sensor_reading_mv, output supply_mv,
                   output manual_run, input ready);
   modport sink   (input valid, input sensor_reading_mv, input supply_mv,
                   input manual_run, output ready);
endinterface

interface smc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [smc_pkg::MV_W-1:0]    adjusted_mv;
   logic                        reading_plausible;
   logic [smc_pkg::PCT_W-1:0]   moisture_percent;
   logic [smc_pkg::SEC_W-1:0]   run_seconds;

   modport source (output valid, output adjusted_mv, output reading_plausible,
                   output moisture_percent, output run_seconds, input ready);
   modport sink   (input valid, input adjusted_mv, input reading_plausible,
                   input moisture_percent, input run_seconds, output ready);
endinterface

### rtl/smc_front.sv
// ----------------------------------------------------------------------------
// Soil moisture conditioner front end
// Three stages: supply correction, window and range compares, numerator build.
// ----------------------------------------------------------------------------
module smc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  smc_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [smc_pkg::MV_W-1:0] sensor_reading_mv,
   input  logic [smc_pkg::MV_W-1:0] supply_mv,
   input  logic                     manual_run,
   output logic                     out_valid,
   input  logic                     out_ready,
   output smc_pkg::pipe_type        out_pipe
);

   typedef struct packed {
      logic [smc_pkg::MV_W-1:0] adjusted_mv;
      logic                     manual_run;
      logic [smc_pkg::MV_W-1:0] lo_bound;
      logic [smc_pkg::MV_W-1:0] hi_bound;
      logic [smc_pkg::MV_W-1:0] clamp_mv;
   } s1_type;

   // stage valid bits and ready chain
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   s1_type            s1_ff, s1_in;
   smc_pkg::pipe_type s2_ff, s2_in;
   smc_pkg::pipe_type s3_ff, s3_in;

   logic [smc_pkg::MV_W-1:0] headroom;
   logic [smc_pkg::MV_W:0]   corr_sum;
   logic [smc_pkg::MV_W:0]   hi_sum;
   logic [smc_pkg::MV_W:0]   clamp_sum;
   logic                     below_knee;
   logic                     inverted, past_clamp, at_wet, past_dry;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: supply correction and config-derived bounds
   always_comb begin
      below_knee = supply_mv < cfg.supply_knee_mv;
      headroom   = cfg.supply_knee_mv - supply_mv;
      corr_sum   = {1'b0, sensor_reading_mv} + {1'b0, headroom};
      hi_sum     = {1'b0, cfg.dry_level_mv} + {1'b0, cfg.high_margin_mv};
      clamp_sum  = {1'b0, cfg.dry_level_mv} + {1'b0, cfg.dry_headroom_mv};

      s1_in.manual_run = manual_run;
      if (below_knee) begin
         s1_in.adjusted_mv = corr_sum[smc_pkg::MV_W] ? smc_pkg::MV_MAX
                                                      : corr_sum[smc_pkg::MV_W-1:0];
      end else begin
         s1_in.adjusted_mv = sensor_reading_mv;
      end
      s1_in.lo_bound = (cfg.wet_level_mv > cfg.low_margin_mv)
                       ? cfg.wet_level_mv - cfg.low_margin_mv : '0;
      s1_in.hi_bound = hi_sum[smc_pkg::MV_W] ? smc_pkg::MV_MAX
                                             : hi_sum[smc_pkg::MV_W-1:0];
      s1_in.clamp_mv = clamp_sum[smc_pkg::MV_W] ? smc_pkg::MV_MAX
                                                : clamp_sum[smc_pkg::MV_W-1:0];
   end

   // stage 2: plausibility window and percentage case
   always_comb begin
      inverted   = cfg.dry_level_mv <= cfg.wet_level_mv;
      past_clamp = s1_ff.adjusted_mv >= s1_ff.clamp_mv;
      at_wet     = s1_ff.adjusted_mv <= cfg.wet_level_mv;
      past_dry   = s1_ff.adjusted_mv >= cfg.dry_level_mv;

      s2_in.adjusted_mv = s1_ff.adjusted_mv;
      s2_in.manual_run  = s1_ff.manual_run;
      s2_in.plausible   = (s1_ff.adjusted_mv >= s1_ff.lo_bound) &&
                          (s1_ff.adjusted_mv <= s1_ff.hi_bound);
      if (inverted || past_clamp) begin
         s2_in.pct_sel = smc_pkg::PCT_SEL_ZERO;
      end else if (at_wet) begin
         s2_in.pct_sel = smc_pkg::PCT_SEL_FULL;
      end else if (past_dry) begin
         s2_in.pct_sel = smc_pkg::PCT_SEL_ZERO;
      end else begin
         s2_in.pct_sel = smc_pkg::PCT_SEL_DIVIDE;
      end
      s2_in.span = cfg.dry_level_mv - cfg.wet_level_mv;
      // rem holds dry - reading here; widened into the numerator next stage
      s2_in.rem  = smc_pkg::REM_W'(cfg.dry_level_mv - s1_ff.adjusted_mv);
      s2_in.quo  = '0;
   end

   // stage 3: numerator = diff * 100 + span / 2 (rounding)
   always_comb begin
      s3_in     = s2_ff;
      s3_in.rem = s2_ff.rem * smc_pkg::REM_W'(smc_pkg::PCT_FULL_SCALE)
                + smc_pkg::REM_W'(s2_ff.span >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid)    s1_ff <= s1_in;
      if (s2_ready && s1_valid_ff) s2_ff <= s2_in;
      if (s3_ready && s2_valid_ff) s3_ff <= s3_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_pipe  = s3_ff;

endmodule

### rtl/smc_div_step.sv
// ----------------------------------------------------------------------------
// Soil moisture conditioner divider step
// One restoring step of the percentage division, one register stage.
// ----------------------------------------------------------------------------
module smc_div_step #(
   parameter int SHIFT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  smc_pkg::pipe_type in_pipe,
   output logic              out_valid,
   input  logic              out_ready,
   output smc_pkg::pipe_type out_pipe
);

   logic                       valid_ff;
   smc_pkg::pipe_type          pipe_ff, pipe_in;
   logic [smc_pkg::REM_W-1:0]  divisor;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      divisor = smc_pkg::REM_W'(in_pipe.span) << SHIFT;
      pipe_in = in_pipe;
      if (in_pipe.rem >= divisor) begin
         pipe_in.rem        = in_pipe.rem - divisor;
         pipe_in.quo[SHIFT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) pipe_ff <= pipe_in;
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

### rtl/smc_back.sv
// ----------------------------------------------------------------------------
// Soil moisture conditioner back end
// Percentage select, duration table, manual rule and result register.
// ----------------------------------------------------------------------------
module smc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  smc_pkg::pipe_type         in_pipe,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [smc_pkg::MV_W-1:0]  adjusted_mv,
   output logic                      reading_plausible,
   output logic [smc_pkg::PCT_W-1:0] moisture_percent,
   output logic [smc_pkg::SEC_W-1:0] run_seconds
);

   logic                      valid_ff;
   logic [smc_pkg::MV_W-1:0]  adjusted_ff;
   logic                      plausible_ff;
   logic [smc_pkg::PCT_W-1:0] pct_ff, pct_in;
   logic [smc_pkg::SEC_W-1:0] secs_ff, secs_in;
   logic [smc_pkg::SEC_W-1:0] table_secs;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      case (in_pipe.pct_sel)
         smc_pkg::PCT_SEL_FULL: begin
            pct_in = smc_pkg::PCT_FULL_SCALE;
         end
         smc_pkg::PCT_SEL_DIVIDE: begin
            pct_in = (in_pipe.quo > smc_pkg::PCT_FULL_SCALE) ? smc_pkg::PCT_FULL_SCALE
                                                             : in_pipe.quo;
         end
         default: begin
            pct_in = smc_pkg::PCT_NONE;
         end
      endcase
      table_secs = smc_pkg::table_seconds(pct_in);
      secs_in    = (in_pipe.manual_run && table_secs == smc_pkg::SEC_0)
                   ? smc_pkg::SEC_10 : table_secs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         adjusted_ff  <= in_pipe.adjusted_mv;
         plausible_ff <= in_pipe.plausible;
         pct_ff       <= pct_in;
         secs_ff      <= secs_in;
      end
   end

   assign out_valid         = valid_ff;
   assign adjusted_mv       = adjusted_ff;
   assign reading_plausible = plausible_ff;
   assign moisture_percent  = pct_ff;
   assign run_seconds       = secs_ff;

endmodule

### rtl/soil_moisture_conditioner.sv
// ----------------------------------------------------------------------------
// Soil moisture conditioner
// Supply correction, plausibility check, moisture percentage and watering time.
// ----------------------------------------------------------------------------
// Takes one sample word per clock, unless the result side stalls, and returns
// one result word per sample, in order, through three front-end stages (supply
// correction, window compares, numerator), seven divider stages that each
// resolve one quotient bit of the rounded percentage division, and the result
// register. Every stage has its own valid bit and fills bubbles, so a stalled
// result side backs up the pipe without losing words. The user must write the
// calibration registers through the csr port while idle; it is not enforced.
module soil_moisture_conditioner (
   input  logic                          clock,
   input  logic                          reset,
   smc_req_if.sink                       req_bus,
   smc_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_en,
   input  logic [smc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [smc_pkg::MV_W-1:0]      csr_wdata
);

   smc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dry_level_mv    <= smc_pkg::DRY_RESET;
         cfg_ff.wet_level_mv    <= smc_pkg::WET_RESET;
         cfg_ff.supply_knee_mv  <= smc_pkg::KNEE_RESET;
         cfg_ff.low_margin_mv   <= smc_pkg::LOW_MARG_RESET;
         cfg_ff.high_margin_mv  <= smc_pkg::HI_MARG_RESET;
         cfg_ff.dry_headroom_mv <= smc_pkg::HEADROOM_RESET;
      end else if (csr_write_en) begin
         case (smc_pkg::csr_index_type'(csr_index))
            smc_pkg::CSR_DRY_LEVEL:    cfg_ff.dry_level_mv    <= csr_wdata;
            smc_pkg::CSR_WET_LEVEL:    cfg_ff.wet_level_mv    <= csr_wdata;
            smc_pkg::CSR_SUPPLY_KNEE:  cfg_ff.supply_knee_mv  <= csr_wdata;
            smc_pkg::CSR_LOW_MARGIN:   cfg_ff.low_margin_mv   <= csr_wdata;
            smc_pkg::CSR_HIGH_MARGIN:  cfg_ff.high_margin_mv  <= csr_wdata;
            smc_pkg::CSR_DRY_HEADROOM: cfg_ff.dry_headroom_mv <= csr_wdata;
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

   logic              div_valid [smc_pkg::DIV_STEPS+1];
   logic              div_ready [smc_pkg::DIV_STEPS+1];
   smc_pkg::pipe_type div_pipe  [smc_pkg::DIV_STEPS+1];

   smc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .in_valid          (req_bus.valid),
      .in_ready          (req_bus.ready),
      .sensor_reading_mv (req_bus.sensor_reading_mv),
      .supply_mv         (req_bus.supply_mv),
      .manual_run        (req_bus.manual_run),
      .out_valid         (div_valid[0]),
      .out_ready         (div_ready[0]),
      .out_pipe          (div_pipe[0])
   );

   // quotient bits resolved MSB first
   for (genvar g = 0; g < smc_pkg::DIV_STEPS; g++) begin : g_div
      smc_div_step #(
         .SHIFT (smc_pkg::DIV_STEPS - 1 - g)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_ready  (div_ready[g]),
         .in_pipe   (div_pipe[g]),
         .out_valid (div_valid[g+1]),
         .out_ready (div_ready[g+1]),
         .out_pipe  (div_pipe[g+1])
      );
   end

   smc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (div_valid[smc_pkg::DIV_STEPS]),
      .in_ready          (div_ready[smc_pkg::DIV_STEPS]),
      .in_pipe           (div_pipe[smc_pkg::DIV_STEPS]),
      .out_valid         (rsp_bus.valid),
      .out_ready         (rsp_bus.ready),
      .adjusted_mv       (rsp_bus.adjusted_mv),
      .reading_plausible (rsp_bus.reading_plausible),
      .moisture_percent  (rsp_bus.moisture_percent),
      .run_seconds       (rsp_bus.run_seconds)
   );

endmodule

### rtl/smc_checker.sv
// ----------------------------------------------------------------------------
// Soil moisture conditioner port checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "soil_moisture_conditioner_macros.svh"

module smc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [smc_pkg::MV_W-1:0]  adjusted_mv,
   input logic                      reading_plausible,
   input logic [smc_pkg::PCT_W-1:0] moisture_percent,
   input logic [smc_pkg::SEC_W-1:0] run_seconds
);

   // words accepted but not yet delivered
   logic [4:0] pending_ff, pending_in;
   logic       req_take, rsp_take;

   logic [smc_pkg::MV_W+smc_pkg::PCT_W+smc_pkg::SEC_W:0] rsp_word;
   logic pct_legal, secs_legal, long_run_ok, no_water_ok;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   assign rsp_word = {adjusted_mv, reading_plausible, moisture_percent, run_seconds};

   assign pct_legal  = moisture_percent <= smc_pkg::PCT_FULL_SCALE;
   assign secs_legal = (run_seconds == smc_pkg::SEC_0)   ||
                       (run_seconds == smc_pkg::SEC_10)  ||
                       (run_seconds == smc_pkg::SEC_60)  ||
                       (run_seconds == smc_pkg::SEC_120) ||
                       (run_seconds == smc_pkg::SEC_180) ||
                       (run_seconds == smc_pkg::SEC_240);

   // below 50 % always waters longest; 81 % and up is no water or the manual 10 s
   assign long_run_ok = (moisture_percent < smc_pkg::PCT_BAND_50) ==
                        (run_seconds == smc_pkg::SEC_240);
   assign no_water_ok = (moisture_percent >= smc_pkg::PCT_NO_WATER) ==
                        ((run_seconds == smc_pkg::SEC_0) ||
                         (run_seconds == smc_pkg::SEC_10 &&
                          moisture_percent != smc_pkg::PCT_SHORT));

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) pending_in = pending_ff + 5'd1;
      if (rsp_take && !req_take) pending_in = pending_ff - 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `SMC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   `SMC_ASSERT_NOW(a_rsp_has_source, rsp_valid, pending_ff != 5'd0)

   `SMC_ASSERT_NOW(a_duration_code, rsp_valid, pct_legal && secs_legal)

   `SMC_ASSERT_NOW(a_duration_band, rsp_valid, long_run_ok && no_water_ok)

endmodule

bind soil_moisture_conditioner smc_checker u_smc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .adjusted_mv       (rsp_bus.adjusted_mv),
   .reading_plausible (rsp_bus.reading_plausible),
   .moisture_percent  (rsp_bus.moisture_percent),
   .run_seconds       (rsp_bus.run_seconds)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Soil moisture conditioner testbench
// Drives sample words into the conditioner and checks every result word
// against an in-bench prediction of the supply correction, the plausibility
// window, the moisture percentage and the watering time. The run covers a
// directed set at the reset calibration, a sweep of calibrations including
// the extremes, an unpaced stretch and a long result-side stall.
// ----------------------------------------------------------------------------
module testbench;

   localparam int IDLE_PERCENT   = 7;
   localparam int HOLD_CYCLES    = 80;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SWEEP_KINDS    = 10;
   localparam int WORDS_PER_CAL  = 90;
   localparam int STALL_WORDS    = 40;

   // indexes outside the register map; writes to them must be ignored
   localparam logic [smc_pkg::CSR_IDX_W-1:0] CSR_FIRST_UNMAPPED = 3'd6;
   localparam logic [smc_pkg::CSR_IDX_W-1:0] CSR_LAST_UNMAPPED  = 3'd7;

   typedef struct {
      logic [smc_pkg::MV_W-1:0]  adjusted_mv;
      logic                      reading_plausible;
      logic [smc_pkg::PCT_W-1:0] moisture_percent;
      logic [smc_pkg::SEC_W-1:0] run_seconds;
   } moisture_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                          csr_write_en;
   logic [smc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [smc_pkg::MV_W-1:0]      csr_wdata;

   smc_req_if req_bus ();
   smc_rsp_if rsp_bus ();

   soil_moisture_conditioner uut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   smc_pkg::cfg_type    cal;
   moisture_result_type pending_results[$];
   moisture_result_type want;
   int                  error_count = 0;
   int                  words_sent = 0;
   int                  results_checked = 0;
   int                  calibrations_applied = 0;
   int                  idle_cycles = 0;
   bit                  idling_on = 1'b1;
   bit                  hold_request = 1'b0;

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic logic [smc_pkg::MV_W-1:0] sat_sum(
      input logic [smc_pkg::MV_W-1:0] a,
      input logic [smc_pkg::MV_W-1:0] b);
      logic [smc_pkg::MV_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[smc_pkg::MV_W] ? smc_pkg::MV_MAX : sum[smc_pkg::MV_W-1:0];
   endfunction

   function automatic logic [smc_pkg::MV_W-1:0] window_low();
      return (cal.wet_level_mv > cal.low_margin_mv) ?
             cal.wet_level_mv - cal.low_margin_mv : '0;
   endfunction

   function automatic logic [smc_pkg::MV_W-1:0] window_high();
      return sat_sum(cal.dry_level_mv, cal.high_margin_mv);
   endfunction

   function automatic logic [smc_pkg::SEC_W-1:0] watering_seconds(input int unsigned pct);
      if (pct >= 81) return 8'd0;
      if (pct == 80) return 8'd10;
      if (pct >= 70) return 8'd60;
      if (pct >= 60) return 8'd120;
      if (pct >= 50) return 8'd180;
      return 8'd240;
   endfunction

   function automatic moisture_result_type condition_sample(
      input logic [smc_pkg::MV_W-1:0] reading,
      input logic [smc_pkg::MV_W-1:0] supply,
      input logic manual);
      moisture_result_type      r;
      logic [smc_pkg::MV_W-1:0] adj;
      int unsigned              dry, wet, rd, clamp_mv, span, pct;
      if (supply < cal.supply_knee_mv)
         adj = sat_sum(reading, cal.supply_knee_mv - supply);
      else
         adj = reading;
      dry      = cal.dry_level_mv;
      wet      = cal.wet_level_mv;
      rd       = adj;
      clamp_mv = sat_sum(cal.dry_level_mv, cal.dry_headroom_mv);
      if (dry <= wet || rd >= clamp_mv) begin
         pct = 0;
      end else if (rd <= wet) begin
         pct = 100;
      end else if (rd >= dry) begin
         pct = 0;
      end else begin
         span = dry - wet;
         pct  = ((dry - rd) * 100 + span / 2) / span;
         if (pct > 100) pct = 100;
      end
      r.adjusted_mv       = adj;
      r.reading_plausible = (adj >= window_low()) && (adj <= window_high());
      r.moisture_percent  = pct[smc_pkg::PCT_W-1:0];
      r.run_seconds       = watering_seconds(pct);
      if (manual && r.run_seconds == 8'd0) r.run_seconds = 8'd10;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // result checking: results are compared first, then the new sample word
   // (if any) is predicted, so same-edge traffic keeps its order
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
               $error("result word with nothing expected: adjusted_mv %0d",
                      rsp_bus.adjusted_mv);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.adjusted_mv !== want.adjusted_mv) begin
                  $error("adjusted_mv: expected %0d, got %0d",
                         want.adjusted_mv, rsp_bus.adjusted_mv);
                  error_count++;
               end
               if (rsp_bus.reading_plausible !== want.reading_plausible) begin
                  $error("reading_plausible: expected %0d, got %0d",
                         want.reading_plausible, rsp_bus.reading_plausible);
                  error_count++;
               end
               if (rsp_bus.moisture_percent !== want.moisture_percent) begin
                  $error("moisture_percent: expected %0d, got %0d",
                         want.moisture_percent, rsp_bus.moisture_percent);
                  error_count++;
               end
               if (rsp_bus.run_seconds !== want.run_seconds) begin
                  $error("run_seconds: expected %0d, got %0d",
                         want.run_seconds, rsp_bus.run_seconds);
                  error_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            pending_results.push_back(condition_sample(req_bus.sensor_reading_mv,
                                                       req_bus.supply_mv,
                                                       req_bus.manual_run));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready) || csr_write_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("soil_moisture_conditioner test failed");
            $finish;
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request  = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready = !(idling_on && $urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers; all start and end on a falling edge
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [smc_pkg::MV_W-1:0] reading,
                            input logic [smc_pkg::MV_W-1:0] supply,
                            input logic manual);
      while (idling_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid             = 1'b1;
      req_bus.sensor_reading_mv = reading;
      req_bus.supply_mv         = supply;
      req_bus.manual_run        = manual;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [smc_pkg::CSR_IDX_W-1:0] index,
                                 input logic [smc_pkg::MV_W-1:0] value);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (index)
         smc_pkg::CSR_DRY_LEVEL:    cal.dry_level_mv    = value;
         smc_pkg::CSR_WET_LEVEL:    cal.wet_level_mv    = value;
         smc_pkg::CSR_SUPPLY_KNEE:  cal.supply_knee_mv  = value;
         smc_pkg::CSR_LOW_MARGIN:   cal.low_margin_mv   = value;
         smc_pkg::CSR_HIGH_MARGIN:  cal.high_margin_mv  = value;
         smc_pkg::CSR_DRY_HEADROOM: cal.dry_headroom_mv = value;
         default: ;
      endcase
   endtask

   task automatic apply_calibration(input logic [smc_pkg::MV_W-1:0] dry,
                                    input logic [smc_pkg::MV_W-1:0] wet,
                                    input logic [smc_pkg::MV_W-1:0] knee,
                                    input logic [smc_pkg::MV_W-1:0] low,
                                    input logic [smc_pkg::MV_W-1:0] high,
                                    input logic [smc_pkg::MV_W-1:0] head);
      wait_drained();
      // stray write first; it must not disturb anything
      write_register(smc_pkg::CSR_IDX_W'($urandom_range(CSR_FIRST_UNMAPPED,
                                                        CSR_LAST_UNMAPPED)),
                     smc_pkg::MV_W'($urandom));
      write_register(smc_pkg::CSR_DRY_LEVEL, dry);
      write_register(smc_pkg::CSR_WET_LEVEL, wet);
      write_register(smc_pkg::CSR_SUPPLY_KNEE, knee);
      write_register(smc_pkg::CSR_LOW_MARGIN, low);
      write_register(smc_pkg::CSR_HIGH_MARGIN, high);
      write_register(smc_pkg::CSR_DRY_HEADROOM, head);
      calibrations_applied++;
   endtask

   task automatic apply_typical_calibration(input logic [smc_pkg::MV_W-1:0] knee,
                                            input logic [smc_pkg::MV_W-1:0] head);
      logic [smc_pkg::MV_W-1:0] wet;
      wet = smc_pkg::MV_W'($urandom_range(200, 2000));
      apply_calibration(wet + smc_pkg::MV_W'($urandom_range(1, 3000)), wet, knee,
                        smc_pkg::MV_W'($urandom_range(0, 500)),
                        smc_pkg::MV_W'($urandom_range(0, 500)), head);
   endtask

   function automatic logic [smc_pkg::MV_W-1:0] near(input int center, input int spread);
      int v;
      v = center - spread + int'($urandom_range(0, 2 * spread));
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return smc_pkg::MV_W'(v);
   endfunction

   // readings cluster around the wet level, the dry clamp and the window
   // bounds; supply mostly at or above the knee
   task automatic send_random_words(input int count);
      logic [smc_pkg::MV_W-1:0] reading, supply;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 5))
            0: reading = smc_pkg::MV_W'($urandom);
            1: reading = near(cal.wet_level_mv, 40);
            2: reading = near(cal.dry_level_mv, int'(cal.dry_headroom_mv) + 40);
            3: reading = (cal.dry_level_mv > cal.wet_level_mv) ?
                         smc_pkg::MV_W'($urandom_range(cal.wet_level_mv,
                                                       cal.dry_level_mv)) :
                         smc_pkg::MV_W'($urandom);
            4: reading = near(window_low(), 3);
            default: reading = near(window_high(), 3);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: supply = smc_pkg::MV_W'($urandom_range(cal.supply_knee_mv,
                                                                     65535));
            6, 7: supply = near(int'(cal.supply_knee_mv) - 100, 100);
            default: supply = smc_pkg::MV_W'($urandom);
         endcase
         send_word(reading, supply, 1'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // reset calibration: window 900..3100, clamp 2900, span 1600
   task automatic test_reset_calibration();
      send_word(16'd0,     16'd0,     1'b0);   // full knee correction
      send_word(16'd65535, 16'd0,     1'b1);   // correction saturates
      send_word(16'd65535, 16'd65535, 1'b0);
      send_word(16'd1200,  16'd3300,  1'b0);   // at wet level
      send_word(16'd1200,  16'd3300,  1'b1);   // manual turns no water into 10 s
      send_word(16'd0,     16'd3300,  1'b1);
      send_word(16'd899,   16'd3300,  1'b0);   // window bounds
      send_word(16'd900,   16'd3300,  1'b0);
      send_word(16'd3100,  16'd3300,  1'b1);
      send_word(16'd3101,  16'd3300,  1'b0);
      send_word(16'd2799,  16'd3300,  1'b0);   // around dry and the dry clamp
      send_word(16'd2800,  16'd3300,  1'b0);
      send_word(16'd2899,  16'd3300,  1'b1);
      send_word(16'd2900,  16'd3300,  1'b0);
      send_word(16'd1504,  16'd3300,  1'b0);   // 81 %
      send_word(16'd1520,  16'd3300,  1'b0);   // 80 %
      send_word(16'd1536,  16'd3300,  1'b1);   // 79 %
      send_word(16'd1680,  16'd3300,  1'b0);   // 70 %
      send_word(16'd1840,  16'd3300,  1'b0);   // 60 %
      send_word(16'd2000,  16'd3300,  1'b0);   // 50 %
      send_word(16'd2016,  16'd3300,  1'b1);   // 49 %
      send_word(16'd1000,  16'd3299,  1'b0);   // just below the knee
      send_word(16'd1000,  16'd3301,  1'b0);
   endtask

   task automatic test_calibration_sweep();
      logic [smc_pkg::MV_W-1:0] level;
      for (int kind = 0; kind < SWEEP_KINDS; kind++) begin
         case (kind)
            0: apply_calibration(smc_pkg::DRY_RESET, smc_pkg::WET_RESET,
                                 smc_pkg::KNEE_RESET, smc_pkg::LOW_MARG_RESET,
                                 smc_pkg::HI_MARG_RESET, smc_pkg::HEADROOM_RESET);
            1: apply_typical_calibration(smc_pkg::MV_W'($urandom_range(2500, 4200)),
                                         smc_pkg::MV_W'($urandom_range(0, 300)));
            2: apply_calibration(smc_pkg::MV_W'($urandom), smc_pkg::MV_W'($urandom),
                                 smc_pkg::MV_W'($urandom), smc_pkg::MV_W'($urandom),
                                 smc_pkg::MV_W'($urandom), smc_pkg::MV_W'($urandom));
            3: apply_calibration('0, '0, '0, '0, '0, '0);
            4: apply_calibration(smc_pkg::MV_MAX, smc_pkg::MV_MAX, smc_pkg::MV_MAX,
                                 smc_pkg::MV_MAX, smc_pkg::MV_MAX, smc_pkg::MV_MAX);
            5: apply_calibration(smc_pkg::MV_MAX, '0, smc_pkg::MV_MAX,
                                 smc_pkg::MV_MAX, smc_pkg::MV_MAX, smc_pkg::MV_MAX);
            6: begin
               // inverted calibration: dry below wet
               level = smc_pkg::MV_W'($urandom_range(1500, 3000));
               apply_calibration(level - smc_pkg::MV_W'($urandom_range(1, 1000)), level,
                                 smc_pkg::KNEE_RESET, 16'd200, 16'd200, 16'd100);
            end
            7: begin
               level = smc_pkg::MV_W'($urandom_range(1000, 3000));
               apply_calibration(level, level, smc_pkg::KNEE_RESET,
                                 16'd200, 16'd200, 16'd100);
            end
            8: begin
               // span of one, low bound clamps at zero, no headroom
               level = smc_pkg::MV_W'($urandom_range(10, 200));
               apply_calibration(level + 16'd1, level, smc_pkg::KNEE_RESET,
                                 level + smc_pkg::MV_W'($urandom_range(0, 500)),
                                 '0, '0);
            end
            default: apply_typical_calibration('0, '0);
         endcase
         send_random_words(WORDS_PER_CAL);
      end
   endtask

   task automatic test_unpaced_stretch();
      apply_typical_calibration(smc_pkg::MV_W'($urandom_range(2500, 4200)),
                                smc_pkg::MV_W'($urandom_range(0, 300)));
      idling_on = 1'b0;
      send_random_words(WORDS_PER_CAL);
      idling_on = 1'b1;
   endtask

   // result side holds off while words keep coming, so the pipe fills up
   task automatic test_result_stall();
      wait_drained();
      hold_request = 1'b1;
      send_random_words(STALL_WORDS);
   endtask

   initial begin
      req_bus.valid             = 1'b0;
      req_bus.sensor_reading_mv = '0;
      req_bus.supply_mv         = '0;
      req_bus.manual_run        = 1'b0;
      csr_write_en              = 1'b0;
      csr_index                 = smc_pkg::CSR_DRY_LEVEL;
      csr_wdata                 = '0;
      cal = '{smc_pkg::DRY_RESET, smc_pkg::WET_RESET, smc_pkg::KNEE_RESET,
              smc_pkg::LOW_MARG_RESET, smc_pkg::HI_MARG_RESET,
              smc_pkg::HEADROOM_RESET};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_calibration();
      test_calibration_sweep();
      test_unpaced_stretch();
      test_result_stall();

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d result words never arrived", pending_results.size());
         error_count++;
      end
      $display("Ran %0d sample words, checked %0d result words, over %0d calibrations",
               words_sent, results_checked, calibrations_applied);
      $display("incl. inverted, zero and full-scale calibrations and a long result stall");
      if (error_count == 0)
         $display("soil_moisture_conditioner test passed");
      else
         $display("soil_moisture_conditioner test failed");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/smc_pkg.sv
rtl/smc_channels.sv
rtl/smc_front.sv
rtl/smc_div_step.sv
rtl/smc_back.sv
rtl/soil_moisture_conditioner.sv
rtl/smc_checker.sv
tb/testbench.sv
